/* rtl/tosa_pkg.sv */
// ----------------------------------------------------------------------------
// tosa_pkg
// Shared widths, codes and state types for the typed operand stack ALU.
// ----------------------------------------------------------------------------
package tosa_pkg;

  localparam int STACK_DEPTH_DEF = 64;

  localparam int MODE_W      = 3;
  localparam int OP_W        = 4;
  localparam int TYPE_W      = 4;
  localparam int VALUE_W     = 32;
  localparam int DEPTH_IDX_W = 6;
  localparam int STATUS_W    = 3;
  localparam int ENTRIES_W   = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 3'd0,
    MODE_POP   = 3'd1,
    MODE_CPOP  = 3'd2,
    MODE_PEEK  = 3'd3,
    MODE_BIN   = 3'd4,
    MODE_UNARY = 3'd5
  } mode_t;

  typedef enum logic [OP_W-1:0] {
    BOP_ADD = 4'd0,
    BOP_SUB = 4'd1,
    BOP_MUL = 4'd2,
    BOP_DIV = 4'd3,
    BOP_AND = 4'd4,
    BOP_OR  = 4'd5,
    BOP_EQ  = 4'd6,
    BOP_NE  = 4'd7,
    BOP_GE  = 4'd8,
    BOP_LE  = 4'd9,
    BOP_GT  = 4'd10,
    BOP_LT  = 4'd11
  } bin_op_t;

  localparam logic [OP_W-1:0] UOP_NEG = 4'd0;
  localparam logic [OP_W-1:0] UOP_NOT = 4'd1;

  localparam logic [TYPE_W-1:0] TAG_INT   = 4'd0;
  localparam logic [TYPE_W-1:0] TAG_BOOL  = 4'd1;
  localparam logic [TYPE_W-1:0] TAG_FLOAT = 4'd2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_UNDER    = 3'd1,
    STAT_OVER     = 3'd2,
    STAT_MISMATCH = 3'd3,
    STAT_DIVZERO  = 3'd4,
    STAT_BADOP    = 3'd5,
    STAT_BADUNARY = 3'd6,
    STAT_FLOAT    = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_DIV,
    S_RESP
  } fsm_t;

endpackage

/* rtl/tosa_if.sv */
// ----------------------------------------------------------------------------
// tosa_in_if / tosa_out_if
// Valid/ready channels for stack operation words and result words.
// ----------------------------------------------------------------------------
interface tosa_in_if;
  logic                                     valid;
  logic                                     ready;
  logic        [tosa_pkg::MODE_W-1:0]       mode;
  logic        [tosa_pkg::OP_W-1:0]         op_code;
  logic        [tosa_pkg::TYPE_W-1:0]       value_type;
  logic signed [tosa_pkg::VALUE_W-1:0]      value;
  logic        [tosa_pkg::DEPTH_IDX_W-1:0]  depth_index;

  modport source (output valid, mode, op_code, value_type, value, depth_index,
                  input ready);
  modport sink   (input valid, mode, op_code, value_type, value, depth_index,
                  output ready);
endinterface

interface tosa_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tosa_pkg::VALUE_W-1:0]    out_value;
  logic        [tosa_pkg::TYPE_W-1:0]     out_type;
  logic        [tosa_pkg::STATUS_W-1:0]   status;
  logic        [tosa_pkg::ENTRIES_W-1:0]  entries_now;

  modport source (output valid, out_value, out_type, status, entries_now,
                  input ready);
  modport sink   (input valid, out_value, out_type, status, entries_now,
                  output ready);
endinterface

/* rtl/tosa_ram.sv */
// ----------------------------------------------------------------------------
// tosa_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tosa_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/tosa_div.sv */
// ----------------------------------------------------------------------------
// tosa_div
// Signed truncating divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tosa_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [tosa_pkg::VALUE_W-1:0]     dividend,
  input  logic [tosa_pkg::VALUE_W-1:0]     divisor,
  output logic                             done,
  output logic [tosa_pkg::VALUE_W-1:0]     quotient
);

  localparam int W     = tosa_pkg::VALUE_W;
  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     quo_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     nb_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [W:0]       shifted;
  logic [W:0]       diff;
  logic             ge;

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, nb_r};
  assign ge      = !diff[W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend[W-1] ? (W'(0) - dividend) : dividend;
      nb_r  <= divisor[W-1] ? (W'(0) - divisor) : divisor;
      neg_r <= dividend[W-1] ^ divisor[W-1];
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo_r <= {quo_r[W-2:0], ge};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (W'(0) - quo_r) : quo_r;

endmodule

/* rtl/typed_operand_stack_alu_unit.sv */
// Accept to result word valid: push and words rejected at accept (underflow,
// overflow, illegal mode or unary opcode) go through S_RESP; pop, peek and
// unary through S_RD1 and S_RESP; binary through S_RD1, S_RD2 and S_RESP, with
// S_DIV for the bit-serial divide before S_RESP. One word in flight; the next is
// taken once the result is in the output register; a stalled output holds input.
// Synchronous active-low reset empties the stack; entry RAM is not cleared.
// ----------------------------------------------------------------------------
// typed_operand_stack_alu_unit
// Typed operand stack with integer/boolean ALU, entries held in one RAM.
// ----------------------------------------------------------------------------
module typed_operand_stack_alu_unit #(
  parameter int STACK_DEPTH = tosa_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tosa_in_if.sink   in_chan,
  tosa_out_if.source out_chan
);

  localparam int VW = tosa_pkg::VALUE_W;
  localparam int TW = tosa_pkg::TYPE_W;
  localparam int RW = VW + TW;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = tosa_pkg::DEPTH_IDX_W;
  localparam int PW = (CW > DW) ? CW : DW;

  tosa_pkg::fsm_t    state_r, state_nxt;
  tosa_pkg::mode_t   mode_r;
  logic [tosa_pkg::OP_W-1:0] op_r;
  logic [TW-1:0]     vtype_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [VW-1:0]     b_val_r, b_val_nxt;
  logic [TW-1:0]     b_type_r, b_type_nxt;
  logic [VW-1:0]     res_value_r, res_value_nxt;
  logic [TW-1:0]     res_type_r, res_type_nxt;
  tosa_pkg::status_t res_status_r, res_status_nxt;

  logic                      out_valid_r;
  logic [VW-1:0]             out_value_r;
  logic [TW-1:0]             out_type_r;
  tosa_pkg::status_t         out_status_r;
  logic [tosa_pkg::ENTRIES_W-1:0] out_entries_r;

  logic          in_fire;
  logic          out_free;
  tosa_pkg::mode_t mode_in;
  logic [CW-1:0] count_m1;
  logic [AW-1:0] top_addr;
  logic [PW-1:0] count_ext;
  logic [PW-1:0] depth_ext;
  logic [PW-1:0] peek_k;
  logic          full;
  logic          empty;

  tosa_pkg::status_t early_st;
  logic          need_read;
  logic [AW-1:0] acc_addr;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;
  logic [VW-1:0] rd_value;
  logic [TW-1:0] rd_type;

  logic [2*VW-1:0]   prod;
  tosa_pkg::status_t bin_st;
  logic [VW-1:0]     bin_value;
  logic [TW-1:0]     bin_type;
  logic              bin_write;
  logic              bin_div;

  logic          div_start;
  logic          div_done;
  logic [VW-1:0] div_q;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign mode_in  = tosa_pkg::mode_t'(in_chan.mode);
  assign count_m1 = count_r - CW'(1);
  assign top_addr = count_m1[AW-1:0];
  assign count_ext = PW'(count_r);
  assign depth_ext = PW'(in_chan.depth_index);
  assign peek_k    = count_ext - PW'(1) - depth_ext;
  assign full      = (count_r == CW'(STACK_DEPTH));
  assign empty     = (count_r == '0);
  assign rd_value  = ram_rdata[VW-1:0];
  assign rd_type   = ram_rdata[RW-1:VW];

  tosa_ram #(
    .WIDTH (RW),
    .DEPTH (STACK_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tosa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_value),
    .divisor  (b_val_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Accept-side checks
  always_comb begin
    early_st  = tosa_pkg::STAT_OK;
    need_read = 1'b0;
    acc_addr  = top_addr;
    case (mode_in)
      tosa_pkg::MODE_PUSH: begin
        if (full) early_st = tosa_pkg::STAT_OVER;
      end
      tosa_pkg::MODE_POP, tosa_pkg::MODE_CPOP: begin
        if (empty) early_st = tosa_pkg::STAT_UNDER;
        else need_read = 1'b1;
      end
      tosa_pkg::MODE_PEEK: begin
        if (depth_ext >= count_ext) begin
          early_st = tosa_pkg::STAT_UNDER;
        end else begin
          need_read = 1'b1;
          acc_addr  = peek_k[AW-1:0];
        end
      end
      tosa_pkg::MODE_BIN: begin
        if (count_r < CW'(2)) early_st = tosa_pkg::STAT_UNDER;
        else need_read = 1'b1;
      end
      tosa_pkg::MODE_UNARY: begin
        if (empty) early_st = tosa_pkg::STAT_UNDER;
        else if (in_chan.op_code > tosa_pkg::UOP_NOT) early_st = tosa_pkg::STAT_BADOP;
        else need_read = 1'b1;
      end
      default: early_st = tosa_pkg::STAT_BADOP;
    endcase
  end

  // Binary ALU: a = lower entry from RAM, b = saved top entry
  assign prod = rd_value * b_val_r;

  always_comb begin
    bin_st    = tosa_pkg::STAT_OK;
    bin_value = '0;
    bin_type  = '0;
    bin_write = 1'b0;
    bin_div   = 1'b0;
    if (rd_type != b_type_r) begin
      bin_st = tosa_pkg::STAT_MISMATCH;
    end else if (op_r > tosa_pkg::BOP_LT) begin
      bin_st = tosa_pkg::STAT_BADOP;
    end else if (op_r <= tosa_pkg::BOP_DIV && rd_type == tosa_pkg::TAG_FLOAT) begin
      bin_st = tosa_pkg::STAT_FLOAT;
    end else begin
      bin_write = 1'b1;
      bin_type  = rd_type;
      case (tosa_pkg::bin_op_t'(op_r))
        tosa_pkg::BOP_ADD: bin_value = rd_value + b_val_r;
        tosa_pkg::BOP_SUB: bin_value = rd_value - b_val_r;
        tosa_pkg::BOP_MUL: bin_value = prod[VW-1:0];
        tosa_pkg::BOP_DIV: begin
          bin_write = 1'b0;
          if (b_val_r == '0) begin
            bin_st    = tosa_pkg::STAT_DIVZERO;
            bin_value = rd_value;
          end else begin
            bin_div = 1'b1;
          end
        end
        tosa_pkg::BOP_AND: bin_value = VW'(rd_value != '0 && b_val_r != '0);
        tosa_pkg::BOP_OR:  bin_value = VW'(rd_value != '0 || b_val_r != '0);
        tosa_pkg::BOP_EQ: begin
          bin_value = VW'(rd_value == b_val_r);
          bin_type  = tosa_pkg::TAG_BOOL;
        end
        tosa_pkg::BOP_NE: begin
          bin_value = VW'(rd_value != b_val_r);
          bin_type  = tosa_pkg::TAG_BOOL;
        end
        tosa_pkg::BOP_GE: begin
          bin_value = VW'(!($signed(rd_value) < $signed(b_val_r)));
          bin_type  = tosa_pkg::TAG_BOOL;
        end
        tosa_pkg::BOP_LE: begin
          bin_value = VW'(!($signed(b_val_r) < $signed(rd_value)));
          bin_type  = tosa_pkg::TAG_BOOL;
        end
        tosa_pkg::BOP_GT: begin
          bin_value = VW'($signed(b_val_r) < $signed(rd_value));
          bin_type  = tosa_pkg::TAG_BOOL;
        end
        tosa_pkg::BOP_LT: begin
          bin_value = VW'($signed(rd_value) < $signed(b_val_r));
          bin_type  = tosa_pkg::TAG_BOOL;
        end
        default: begin
          bin_value = '0;
          bin_write = 1'b0;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tosa_pkg::S_IDLE: begin
        if (in_fire) state_nxt = need_read ? tosa_pkg::S_RD1 : tosa_pkg::S_RESP;
      end
      tosa_pkg::S_RD1: begin
        state_nxt = (mode_r == tosa_pkg::MODE_BIN) ? tosa_pkg::S_RD2 : tosa_pkg::S_RESP;
      end
      tosa_pkg::S_RD2: begin
        state_nxt = bin_div ? tosa_pkg::S_DIV : tosa_pkg::S_RESP;
      end
      tosa_pkg::S_DIV: begin
        if (div_done) state_nxt = tosa_pkg::S_RESP;
      end
      tosa_pkg::S_RESP: begin
        if (out_free) state_nxt = tosa_pkg::S_IDLE;
      end
      default: state_nxt = tosa_pkg::S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    count_nxt      = count_r;
    b_val_nxt      = b_val_r;
    b_type_nxt     = b_type_r;
    res_value_nxt  = res_value_r;
    res_type_nxt   = res_type_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_waddr      = top_addr;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = top_addr;
    div_start      = 1'b0;
    case (state_r)
      tosa_pkg::S_IDLE: begin
        if (in_fire) begin
          res_value_nxt  = '0;
          res_type_nxt   = '0;
          res_status_nxt = early_st;
          ram_re         = need_read;
          ram_raddr      = acc_addr;
          if (early_st == tosa_pkg::STAT_OK) begin
            case (mode_in)
              tosa_pkg::MODE_PUSH: begin
                ram_we    = 1'b1;
                ram_waddr = count_r[AW-1:0];
                ram_wdata = {in_chan.value_type, in_chan.value};
                count_nxt = count_r + CW'(1);
              end
              tosa_pkg::MODE_POP, tosa_pkg::MODE_CPOP, tosa_pkg::MODE_BIN: begin
                count_nxt = count_m1;
              end
              default: count_nxt = count_r;
            endcase
          end
        end
      end
      tosa_pkg::S_RD1: begin
        case (mode_r)
          tosa_pkg::MODE_POP, tosa_pkg::MODE_CPOP: begin
            res_type_nxt = rd_type;
            if (mode_r == tosa_pkg::MODE_CPOP && rd_type != vtype_r) begin
              res_status_nxt = tosa_pkg::STAT_MISMATCH;
            end else begin
              res_value_nxt = rd_value;
            end
          end
          tosa_pkg::MODE_PEEK: begin
            res_type_nxt  = rd_type;
            res_value_nxt = rd_value;
          end
          tosa_pkg::MODE_UNARY: begin
            if (op_r == tosa_pkg::UOP_NEG && rd_type == tosa_pkg::TAG_INT) begin
              res_value_nxt = VW'(0) - rd_value;
              res_type_nxt  = rd_type;
              ram_we        = 1'b1;
              ram_wdata     = {rd_type, VW'(0) - rd_value};
            end else if (op_r == tosa_pkg::UOP_NOT && rd_type == tosa_pkg::TAG_BOOL) begin
              res_value_nxt = VW'(rd_value == '0);
              res_type_nxt  = rd_type;
              ram_we        = 1'b1;
              ram_wdata     = {rd_type, VW'(rd_value == '0)};
            end else begin
              res_status_nxt = tosa_pkg::STAT_BADUNARY;
            end
          end
          tosa_pkg::MODE_BIN: begin
            b_val_nxt  = rd_value;
            b_type_nxt = rd_type;
            ram_re     = 1'b1;
            ram_raddr  = top_addr;
          end
          default: res_status_nxt = tosa_pkg::STAT_BADOP;
        endcase
      end
      tosa_pkg::S_RD2: begin
        res_status_nxt = bin_st;
        res_value_nxt  = bin_value;
        res_type_nxt   = bin_type;
        ram_we         = bin_write;
        ram_wdata      = {bin_type, bin_value};
        div_start      = bin_div;
      end
      tosa_pkg::S_DIV: begin
        if (div_done) begin
          res_value_nxt = div_q;
          ram_we        = 1'b1;
          ram_wdata     = {res_type_r, div_q};
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tosa_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == tosa_pkg::S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r  <= mode_in;
      op_r    <= in_chan.op_code;
      vtype_r <= in_chan.value_type;
    end
    b_val_r      <= b_val_nxt;
    b_type_r     <= b_type_nxt;
    res_value_r  <= res_value_nxt;
    res_type_r   <= res_type_nxt;
    res_status_r <= res_status_nxt;
    if (state_r == tosa_pkg::S_RESP && out_free) begin
      out_value_r   <= res_value_r;
      out_type_r    <= res_type_r;
      out_status_r  <= res_status_r;
      out_entries_r <= tosa_pkg::ENTRIES_W'(count_r);
    end
  end

  assign in_chan.ready        = (state_r == tosa_pkg::S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_value   = out_value_r;
  assign out_chan.out_type    = out_type_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.entries_now = out_entries_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(count_r))
    else $error("stack count moved without an accepted word");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == tosa_pkg::S_DIV)
    else $error("divider finished outside divide wait");

  a_resp_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tosa_pkg::S_RESP && out_free) |=> out_valid_r)
    else $error("result word not presented");

endmodule

/* tb/typed_operand_stack_alu_unit_tb.sv */
// ----------------------------------------------------------------------------
// typed_operand_stack_alu_unit_tb
// Drives stack operation words into the typed operand stack ALU with random
// gaps, stalls the result channel at random and checks every result word
// against a tagged stack predictor kept inside a small scoreboard class.
// ----------------------------------------------------------------------------
module typed_operand_stack_alu_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH_MAX = tosa_pkg::STACK_DEPTH_DEF;
  localparam int MW  = tosa_pkg::MODE_W;
  localparam int OPW = tosa_pkg::OP_W;
  localparam int TGW = tosa_pkg::TYPE_W;
  localparam int VW  = tosa_pkg::VALUE_W;
  localparam int DIW = tosa_pkg::DEPTH_IDX_W;
  localparam int SW  = tosa_pkg::STATUS_W;
  localparam int EW  = tosa_pkg::ENTRIES_W;

  typedef struct {
    logic [MW-1:0]  mode;
    logic [OPW-1:0] op;
    logic [TGW-1:0] vtype;
    logic [VW-1:0]  value;
    logic [DIW-1:0] depth;
  } op_word_t;

  typedef struct {
    logic [VW-1:0]  value;
    logic [TGW-1:0] vtype;
    logic [SW-1:0]  status;
    logic [EW-1:0]  entries;
  } result_t;

  class stack_scoreboard_t;
    logic [VW-1:0]  vals [DEPTH_MAX];
    logic [TGW-1:0] tags [DEPTH_MAX];
    int             count;
    result_t        expected_q [$];
    int             errors;
    int             checked;
    int             accepted;
    int             status_hits [8];

    function void note_op(op_word_t w);
      result_t r;
      logic [VW-1:0] a, b, res, na, nb;
      logic [TGW-1:0] ta, tb, rt;
      int lo;
      r.value = '0;
      r.vtype = '0;
      r.status = tosa_pkg::STAT_OK;
      accepted++;
      case (w.mode)
        tosa_pkg::MODE_PUSH: begin
          if (count >= DEPTH_MAX) begin
            r.status = tosa_pkg::STAT_OVER;
          end else begin
            vals[count] = w.value;
            tags[count] = w.vtype;
            count++;
          end
        end
        tosa_pkg::MODE_POP, tosa_pkg::MODE_CPOP: begin
          if (count == 0) begin
            r.status = tosa_pkg::STAT_UNDER;
          end else begin
            count--;
            r.vtype = tags[count];
            if (w.mode == tosa_pkg::MODE_CPOP && tags[count] != w.vtype)
              r.status = tosa_pkg::STAT_MISMATCH;
            else r.value = vals[count];
          end
        end
        tosa_pkg::MODE_PEEK: begin
          if (int'(w.depth) >= count) begin
            r.status = tosa_pkg::STAT_UNDER;
          end else begin
            lo = count - 1 - int'(w.depth);
            r.value = vals[lo];
            r.vtype = tags[lo];
          end
        end
        tosa_pkg::MODE_BIN: begin
          if (count < 2) begin
            r.status = tosa_pkg::STAT_UNDER;
          end else begin
            lo = count - 2;
            a = vals[lo];
            b = vals[lo+1];
            ta = tags[lo];
            tb = tags[lo+1];
            res = a;
            rt = ta;
            count--;
            if (ta != tb) begin
              r.status = tosa_pkg::STAT_MISMATCH;
            end else if (w.op > tosa_pkg::BOP_LT) begin
              r.status = tosa_pkg::STAT_BADOP;
            end else if (w.op <= tosa_pkg::BOP_DIV && ta == tosa_pkg::TAG_FLOAT) begin
              r.status = tosa_pkg::STAT_FLOAT;
            end else begin
              case (w.op)
                tosa_pkg::BOP_ADD: res = a + b;
                tosa_pkg::BOP_SUB: res = a - b;
                tosa_pkg::BOP_MUL: res = a * b;
                tosa_pkg::BOP_DIV: begin
                  if (b == '0) begin
                    r.status = tosa_pkg::STAT_DIVZERO;
                  end else begin
                    na = a[31] ? -a : a;
                    nb = b[31] ? -b : b;
                    res = na / nb;
                    if (a[31] ^ b[31]) res = -res;
                  end
                end
                tosa_pkg::BOP_AND: res = (a != 0 && b != 0) ? 32'd1 : 32'd0;
                tosa_pkg::BOP_OR:  res = (a != 0 || b != 0) ? 32'd1 : 32'd0;
                tosa_pkg::BOP_EQ:  res = (a == b) ? 32'd1 : 32'd0;
                tosa_pkg::BOP_NE:  res = (a != b) ? 32'd1 : 32'd0;
                tosa_pkg::BOP_GE:  res = ($signed(a) >= $signed(b)) ? 32'd1 : 32'd0;
                tosa_pkg::BOP_LE:  res = ($signed(a) <= $signed(b)) ? 32'd1 : 32'd0;
                tosa_pkg::BOP_GT:  res = ($signed(a) > $signed(b)) ? 32'd1 : 32'd0;
                default:           res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
              endcase
              if (w.op >= tosa_pkg::BOP_EQ) rt = tosa_pkg::TAG_BOOL;
              vals[lo] = res;
              tags[lo] = rt;
              r.value = res;
              r.vtype = rt;
            end
          end
        end
        tosa_pkg::MODE_UNARY: begin
          if (count == 0) begin
            r.status = tosa_pkg::STAT_UNDER;
          end else begin
            lo = count - 1;
            if (w.op > tosa_pkg::UOP_NOT) begin
              r.status = tosa_pkg::STAT_BADOP;
            end else if (w.op == tosa_pkg::UOP_NEG && tags[lo] != tosa_pkg::TAG_INT) begin
              r.status = tosa_pkg::STAT_BADUNARY;
            end else if (w.op == tosa_pkg::UOP_NOT && tags[lo] != tosa_pkg::TAG_BOOL) begin
              r.status = tosa_pkg::STAT_BADUNARY;
            end else begin
              if (w.op == tosa_pkg::UOP_NEG) vals[lo] = -vals[lo];
              else vals[lo] = (vals[lo] == '0) ? 32'd1 : 32'd0;
              r.value = vals[lo];
              r.vtype = tags[lo];
            end
          end
        end
        default: r.status = tosa_pkg::STAT_BADOP;
      endcase
      r.entries = count[EW-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: value %0d type %0d status %0d entries %0d",
               $signed(got.value), got.vtype, got.status, got.entries);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      status_hits[got.status]++;
      if (got.value !== want.value) begin
        $error("out_value: expected %0d, got %0d", $signed(want.value), $signed(got.value));
        errors++;
      end
      if (got.vtype !== want.vtype) begin
        $error("out_type: expected %0d, got %0d", want.vtype, got.vtype);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.entries !== want.entries) begin
        $error("entries_now: expected %0d, got %0d", want.entries, got.entries);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   quiet_phase = 1'b0;

  stack_scoreboard_t sb = new();

  tosa_in_if  op_ch ();
  tosa_out_if res_ch ();

  typed_operand_stack_alu_unit #(.STACK_DEPTH(DEPTH_MAX)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (op_ch),
    .out_chan (res_ch)
  );

  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [TGW-1:0] random_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return tosa_pkg::TAG_INT;
    if (r < 80) return tosa_pkg::TAG_BOOL;
    if (r < 92) return tosa_pkg::TAG_FLOAT;
    return TGW'($urandom_range(0, 15));
  endfunction

  function automatic logic [VW-1:0] random_value(logic [TGW-1:0] tag);
    int r;
    r = $urandom_range(0, 9);
    if (tag == tosa_pkg::TAG_BOOL && r < 8) return $urandom_range(0, 1);
    case (r)
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'hFFFF_FFFF;
      4, 5, 6: return $urandom_range(0, 16) - 8;
      default: return $urandom;
    endcase
  endfunction

  // grow_pct sets the push share; the rest is mostly binary and unary work
  function automatic op_word_t pick_word(int grow_pct);
    op_word_t w;
    int n, r;
    logic [TGW-1:0] top_tag;
    n = sb.count;
    top_tag = (n > 0) ? sb.tags[n-1] : tosa_pkg::TAG_INT;
    w.mode = tosa_pkg::MODE_PUSH;
    w.op = OPW'($urandom_range(0, 15));
    w.vtype = (n > 0 && $urandom_range(0, 9) < 5) ? top_tag : random_tag();
    w.value = random_value(w.vtype);
    w.depth = DIW'($urandom_range(0, 63));
    if ($urandom_range(0, 99) >= grow_pct) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        w.mode = tosa_pkg::MODE_BIN;
        w.op = ($urandom_range(0, 19) == 0) ? OPW'($urandom_range(12, 15))
                                             : OPW'($urandom_range(0, 11));
      end else if (r < 55) begin
        w.mode = tosa_pkg::MODE_UNARY;
        if ($urandom_range(0, 14) == 0) w.op = OPW'($urandom_range(2, 15));
        else if (top_tag == tosa_pkg::TAG_BOOL) w.op = tosa_pkg::UOP_NOT;
        else if (top_tag == tosa_pkg::TAG_INT) w.op = tosa_pkg::UOP_NEG;
        else w.op = OPW'($urandom_range(0, 1));
      end else if (r < 67) begin
        w.mode = tosa_pkg::MODE_POP;
      end else if (r < 79) begin
        w.mode = tosa_pkg::MODE_CPOP;
        if ($urandom_range(0, 3) != 0) w.vtype = top_tag;
      end else if (r < 94) begin
        w.mode = tosa_pkg::MODE_PEEK;
        if (n > 0 && $urandom_range(0, 4) != 0) w.depth = DIW'($urandom_range(0, n - 1));
      end else begin
        w.mode = MW'($urandom_range(6, 7));
      end
    end
    return w;
  endfunction

  task automatic send_word(op_word_t w);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      op_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_ch.valid       <= 1'b1;
    op_ch.mode        <= w.mode;
    op_ch.op_code     <= w.op;
    op_ch.value_type  <= w.vtype;
    op_ch.value       <= w.value;
    op_ch.depth_index <= w.depth;
    do @(posedge clk); while (!op_ch.ready);
    sb.note_op(w);
  endtask

  task automatic send_op(int mode, int op, int tag, logic [VW-1:0] value, int depth);
    op_word_t w;
    w.mode = MW'(mode);
    w.op = OPW'(op);
    w.vtype = TGW'(tag);
    w.value = value;
    w.depth = DIW'(depth);
    send_word(w);
  endtask

  initial begin
    int stall;
    result_t got;
    res_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got.value   = res_ch.out_value;
      got.vtype   = res_ch.out_type;
      got.status  = res_ch.status;
      got.entries = res_ch.entries_now;
      sb.check_result(got);
    end
  end

  initial begin
    int seg, k, grow_pct;
    op_ch.valid       = 1'b0;
    op_ch.mode        = tosa_pkg::MODE_PUSH;
    op_ch.op_code     = '0;
    op_ch.value_type  = '0;
    op_ch.value       = '0;
    op_ch.depth_index = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty stack and illegal modes
    send_op(tosa_pkg::MODE_POP, 0, tosa_pkg::TAG_INT, 0, 0);
    send_op(tosa_pkg::MODE_CPOP, 0, tosa_pkg::TAG_INT, 0, 0);
    send_op(tosa_pkg::MODE_PEEK, 0, tosa_pkg::TAG_INT, 0, 0);
    send_op(tosa_pkg::MODE_UNARY, tosa_pkg::UOP_NEG, tosa_pkg::TAG_INT, 0, 0);
    send_op(tosa_pkg::MODE_BIN, tosa_pkg::BOP_ADD, tosa_pkg::TAG_INT, 0, 0);
    send_op(6, 0, tosa_pkg::TAG_INT, 0, 0);
    send_op(7, 15, 15, 32'hFFFF_FFFF, 63);
    // most negative over minus one, divide by zero, negate wrap
    send_op(tosa_pkg::MODE_PUSH, 0, tosa_pkg::TAG_INT, 32'h8000_0000, 0);
    send_op(tosa_pkg::MODE_BIN, tosa_pkg::BOP_SUB, tosa_pkg::TAG_INT, 0, 0);
    send_op(tosa_pkg::MODE_PUSH, 0, tosa_pkg::TAG_INT, 32'hFFFF_FFFF, 0);
    send_op(tosa_pkg::MODE_BIN, tosa_pkg::BOP_DIV, tosa_pkg::TAG_INT, 0, 0);
    send_op(tosa_pkg::MODE_UNARY, tosa_pkg::UOP_NEG, tosa_pkg::TAG_INT, 0, 0);
    send_op(tosa_pkg::MODE_PUSH, 0, tosa_pkg::TAG_INT, 32'h0, 0);
    send_op(tosa_pkg::MODE_BIN, tosa_pkg::BOP_DIV, tosa_pkg::TAG_INT, 0, 0);
    send_op(tosa_pkg::MODE_PUSH, 0, tosa_pkg::TAG_INT, 32'h7FFF_FFFF, 0);
    send_op(tosa_pkg::MODE_BIN, 15, tosa_pkg::TAG_INT, 0, 0);
    // tag mismatches and float arithmetic
    send_op(tosa_pkg::MODE_PUSH, 0, tosa_pkg::TAG_BOOL, 32'h1, 0);
    send_op(tosa_pkg::MODE_BIN, tosa_pkg::BOP_MUL, tosa_pkg::TAG_INT, 0, 0);
    send_op(tosa_pkg::MODE_CPOP, 0, tosa_pkg::TAG_BOOL, 0, 0);
    send_op(tosa_pkg::MODE_PUSH, 0, tosa_pkg::TAG_FLOAT, 32'hFFFF_FFFF, 0);
    send_op(tosa_pkg::MODE_PUSH, 0, tosa_pkg::TAG_FLOAT, 32'h4000_0000, 0);
    send_op(tosa_pkg::MODE_BIN, tosa_pkg::BOP_SUB, tosa_pkg::TAG_INT, 0, 0);
    send_op(tosa_pkg::MODE_UNARY, tosa_pkg::UOP_NOT, tosa_pkg::TAG_INT, 0, 0);
    send_op(tosa_pkg::MODE_UNARY, 15, tosa_pkg::TAG_INT, 0, 0);
    send_op(tosa_pkg::MODE_PEEK, 0, tosa_pkg::TAG_INT, 0, 63);

    for (seg = 0; seg < 10; seg++) begin
      quiet_phase = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: grow_pct = 60;
        1: grow_pct = 40;
        default: grow_pct = 20;
      endcase
      if (seg == 0) grow_pct = 60;
      if (seg == 3) begin
        // fill to the top, then overflow and reach the deepest entry
        while (sb.count < DEPTH_MAX)
          send_op(tosa_pkg::MODE_PUSH, 0, random_tag(), $urandom, 0);
        send_op(tosa_pkg::MODE_PUSH, 0, tosa_pkg::TAG_INT, $urandom, 0);
        send_op(tosa_pkg::MODE_PUSH, 0, $urandom_range(0, 15), $urandom, 0);
        send_op(tosa_pkg::MODE_PEEK, 0, tosa_pkg::TAG_INT, 0, DEPTH_MAX - 1);
        send_op(tosa_pkg::MODE_BIN, $urandom_range(0, 11), tosa_pkg::TAG_INT, 0, 0);
        send_op(tosa_pkg::MODE_PUSH, 0, tosa_pkg::TAG_BOOL, 0, 0);
        send_op(tosa_pkg::MODE_PUSH, 0, tosa_pkg::TAG_BOOL, 1, 0);
      end
      for (k = 0; k < 45; k++)
        send_word(pick_word(grow_pct));
    end
    quiet_phase = 1'b0;
    op_ch.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d stack operation words, checked %0d result words, %0d mismatches",
             sb.accepted, sb.checked, sb.errors);
    $display("Status seen: ok %0d under %0d over %0d type %0d div0 %0d badop %0d unary %0d float %0d",
             sb.status_hits[tosa_pkg::STAT_OK], sb.status_hits[tosa_pkg::STAT_UNDER],
             sb.status_hits[tosa_pkg::STAT_OVER], sb.status_hits[tosa_pkg::STAT_MISMATCH],
             sb.status_hits[tosa_pkg::STAT_DIVZERO], sb.status_hits[tosa_pkg::STAT_BADOP],
             sb.status_hits[tosa_pkg::STAT_BADUNARY], sb.status_hits[tosa_pkg::STAT_FLOAT]);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
